FILE: hdl/dual_reader_overwrite_ring_top_macros.svh
// Assertion macros for the dual reader ring store.
// Used by dual_reader_overwrite_ring_top; relies on i_clk and i_rst_n in the including scope.
`ifndef DUAL_READER_OVERWRITE_RING_TOP_MACROS_SVH
`define DUAL_READER_OVERWRITE_RING_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DROR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DROR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dror_pkg.sv
// Shared types and request codes for the dual reader ring store.
// No dependencies; compiled before the interface and the top level.
package dror_pkg;

    localparam int FILL_W = 11;
    localparam int SMP_W  = 24;

    localparam logic [2:0] REQ_WRITE    = 3'd0;
    localparam logic [2:0] REQ_ADV_PROC = 3'd1;
    localparam logic [2:0] REQ_ADV_USB  = 3'd2;
    localparam logic [2:0] REQ_RD_PROC  = 3'd3;
    localparam logic [2:0] REQ_RD_USB   = 3'd4;

    typedef struct packed {
        logic [2:0]              req_type;
        logic signed [SMP_W-1:0] sample;
        logic [FILL_W-1:0]       amount;
        logic [FILL_W-1:0]       offset;
    } t_req_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] read_data;
        logic [FILL_W-1:0]       proc_fill;
        logic [FILL_W-1:0]       usb_fill;
        logic                    overran_proc;
        logic                    overran_usb;
        logic                    range_fault;
    } t_rsp_word;

endpackage

FILE: hdl/dror_chan_if.sv
// Valid/ready channel carrying one word of type T.
// Instantiated with dror_pkg::t_req_word and dror_pkg::t_rsp_word.
interface dror_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/dual_reader_overwrite_ring_top.sv
// Top level of the dual reader ring store: sample memory, heads, fills and result pipeline.
// Depends on dror_pkg, dror_chan_if and dual_reader_overwrite_ring_top_macros.svh.
//
// Usage: i_req carries request words (write a sample, advance a reader, read through a
// reader); o_rsp returns exactly one result word per request, in request order, holding
// the read sample (zero unless a read), both fills after the request and the fault flags.
// Throughput is one request per cycle while the receiver is ready: heads and fills
// update in the cycle of acceptance, and the sample memory needs at most one port
// access per request, write or registered read. A memory stage and an output register
// sit in the result path, so one more request is taken while a result waits on a
// stalled receiver; after that i_req.ready drops until the output register is freed.
// The ring holds DEPTH samples; a write to a full reader pushes that reader's head
// and reports an overrun. Reset (synchronous, active low) clears both valid bits, all
// heads and both fills and needs no clearing pass; memory contents stay undefined until
// written and must not be read through a reader before that.
module dual_reader_overwrite_ring_top #(
    parameter int DEPTH = 1536
) (
    input logic          i_clk,
    input logic          i_rst_n,
    dror_chan_if.sink    i_req,
    dror_chan_if.source  o_rsp
);
    import dror_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int XW = ((AW > FILL_W) ? AW : FILL_W) + 1;
    localparam int KW = ((CW > FILL_W) ? CW : FILL_W) + 1;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);
    localparam longint OFF_MAX = (longint'(1) << FILL_W) - 1;

    logic [AW-1:0] r_write_head, n_write_head;
    logic [AW-1:0] r_proc_head, n_proc_head;
    logic [AW-1:0] r_usb_head, n_usb_head;
    logic [CW-1:0] r_proc_count, n_proc_count;
    logic [CW-1:0] r_usb_count, n_usb_count;

    logic [SMP_W-1:0] r_mem [DEPTH];
    logic [SMP_W-1:0] r_mem_q;

    logic      r_a_valid;
    logic      r_a_is_rd;
    t_rsp_word r_a_rsp;
    logic      r_o_valid;
    t_rsp_word r_o;
    t_rsp_word n_a_rsp;
    t_rsp_word n_o;

    logic accept, a_adv, a_to_o, wr_en, rd_en, is_rd;
    logic proc_full;
    logic [2:0] req;

    logic [FILL_W-1:0] off_m;
    logic [AW-1:0]     rd_head;
    logic [CW-1:0]     rd_cnt;
    logic [XW-1:0]     addr_sum;
    logic [AW-1:0]     rd_addr;
    logic              rd_fault;

    logic [AW-1:0] adv_head;
    logic [CW-1:0] adv_cnt;
    logic [CW-1:0] adv_n;
    logic          adv_fault;
    logic [SW-1:0] adv_sum;
    logic [AW-1:0] adv_head_new;

    assign req    = i_req.data.req_type;
    assign a_adv  = !r_o_valid || o_rsp.ready;
    assign a_to_o = a_adv && r_a_valid;
    assign i_req.ready = !r_a_valid || a_adv;
    assign accept = i_req.valid && i_req.ready;
    assign is_rd  = (req == REQ_RD_PROC) || (req == REQ_RD_USB);
    assign wr_en  = accept && (req == REQ_WRITE);
    assign rd_en  = accept && is_rd;
    assign proc_full = (r_proc_count == FULL);

    // Offset reduced modulo DEPTH by subtracting shifted multiples that fit in the field.
    always_comb begin
        off_m = i_req.data.offset;
        for (int k = FILL_W; k >= 0; k--) begin
            if ((longint'(DEPTH) << k) <= OFF_MAX) begin
                if (longint'(off_m) >= (longint'(DEPTH) << k)) begin
                    off_m = off_m - FILL_W'(longint'(DEPTH) << k);
                end
            end
        end
    end

    always_comb begin
        rd_head  = (req == REQ_RD_PROC) ? r_proc_head : r_usb_head;
        rd_cnt   = (req == REQ_RD_PROC) ? r_proc_count : r_usb_count;
        addr_sum = XW'(rd_head) + XW'(off_m);
        if (addr_sum >= XW'(DEPTH)) begin
            addr_sum = addr_sum - XW'(DEPTH);
        end
        rd_addr  = addr_sum[AW-1:0];
        rd_fault = KW'(i_req.data.offset) >= KW'(rd_cnt);
    end

    // Advance path: the amount is clamped to the fill, so head plus amount stays below 2*DEPTH.
    always_comb begin
        adv_head = (req == REQ_ADV_PROC) ? r_proc_head : r_usb_head;
        adv_cnt  = (req == REQ_ADV_PROC) ? r_proc_count : r_usb_count;
        if (KW'(i_req.data.amount) > KW'(adv_cnt)) begin
            adv_n     = adv_cnt;
            adv_fault = 1'b1;
        end else begin
            adv_n     = CW'(i_req.data.amount);
            adv_fault = 1'b0;
        end
        adv_sum = SW'(adv_head) + SW'(adv_n);
        if (adv_sum >= SW'(DEPTH)) begin
            adv_sum = adv_sum - SW'(DEPTH);
        end
        adv_head_new = adv_sum[AW-1:0];
    end

    always_comb begin
        n_write_head = r_write_head;
        n_proc_head  = r_proc_head;
        n_usb_head   = r_usb_head;
        n_proc_count = r_proc_count;
        n_usb_count  = r_usb_count;
        n_a_rsp      = '0;
        case (req)
            REQ_WRITE: begin
                n_write_head = (r_write_head == LAST) ? '0 : r_write_head + 1'b1;
                if (r_proc_count >= FULL) begin
                    n_proc_head = (r_proc_head == LAST) ? '0 : r_proc_head + 1'b1;
                    n_a_rsp.overran_proc = 1'b1;
                end else begin
                    n_proc_count = r_proc_count + 1'b1;
                end
                if (r_usb_count >= FULL) begin
                    n_usb_head = (r_usb_head == LAST) ? '0 : r_usb_head + 1'b1;
                    n_a_rsp.overran_usb = 1'b1;
                end else begin
                    n_usb_count = r_usb_count + 1'b1;
                end
            end
            REQ_ADV_PROC: begin
                n_proc_head  = adv_head_new;
                n_proc_count = r_proc_count - adv_n;
                n_a_rsp.range_fault = adv_fault;
            end
            REQ_ADV_USB: begin
                n_usb_head  = adv_head_new;
                n_usb_count = r_usb_count - adv_n;
                n_a_rsp.range_fault = adv_fault;
            end
            REQ_RD_PROC, REQ_RD_USB: begin
                n_a_rsp.range_fault = rd_fault;
            end
            default: begin
            end
        endcase
        n_a_rsp.proc_fill = FILL_W'(n_proc_count);
        n_a_rsp.usb_fill  = FILL_W'(n_usb_count);
    end

    // The read sample joins the rest of the result word on its way to the output register.
    always_comb begin
        n_o           = r_a_rsp;
        n_o.read_data = r_a_is_rd ? r_mem_q : '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_write_head] <= i_req.data.sample;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_head <= '0;
            r_proc_head  <= '0;
            r_usb_head   <= '0;
            r_proc_count <= '0;
            r_usb_count  <= '0;
            r_a_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_write_head <= n_write_head;
                r_proc_head  <= n_proc_head;
                r_usb_head   <= n_usb_head;
                r_proc_count <= n_proc_count;
                r_usb_count  <= n_usb_count;
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_rsp   <= n_a_rsp;
            r_a_is_rd <= is_rd;
        end
        if (a_to_o) begin
            r_o <= n_o;
        end
    end

    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o;

`include "dual_reader_overwrite_ring_top_macros.svh"

    `DROR_ASSERT_NEXT(a_full_stays_full, wr_en && proc_full, proc_full, "full fill dropped")
    `DROR_ASSERT_NOW(a_overrun_fill, r_o_valid && r_o.overran_proc, r_o.proc_fill == FULL_FILL, "overrun not full")
    `DROR_ASSERT_NOW(a_stall_room, accept && r_o_valid && !o_rsp.ready, !r_a_valid, "taken with no room")
    `DROR_ASSERT_NEXT(a_read_zero, a_to_o && !r_a_is_rd, r_o.read_data == '0, "data on non-read")

endmodule
